@@ sv/urlre_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package urlre_pkg;

  localparam logic [7:0] PCT_CHAR = 8'h25;

  localparam logic [1:0] CLS_NONE     = 2'd0;
  localparam logic [1:0] CLS_RESERVED = 2'd1;
  localparam logic [1:0] CLS_UNSAFE   = 2'd2;
  localparam logic [1:0] CLS_BOTH     = 2'd3;

  // one decision of the front: a byte to send as is, or to send as %XX
  typedef struct packed {
    logic [7:0] data;
    logic       esc;
    logic       last;
  } act_t;

  function automatic logic [1:0] char_class(input logic [7:0] c);
    logic [1:0] cls;
    cls = CLS_NONE;
    if (c[7] || c < 8'h20) begin
      cls = CLS_UNSAFE;
    end else begin
      unique case (c)
        8'h20, 8'h22, 8'h25, 8'h3C, 8'h3E, 8'h5C, 8'h5E, 8'h60,
        8'h7B, 8'h7C, 8'h7D, 8'h7E, 8'h7F: cls = CLS_UNSAFE;
        8'h23, 8'h3A, 8'h40, 8'h5B, 8'h5D: cls = CLS_BOTH;
        8'h26, 8'h2B, 8'h2F, 8'h3B, 8'h3D, 8'h3F: cls = CLS_RESERVED;
        default: cls = CLS_NONE;
      endcase
    end
    return cls;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  // valid only for hex digits: letters of either case have bit 6 set
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    return c[3:0] + (c[6] ? 4'd9 : 4'd0);
  endfunction

  function automatic logic [7:0] hex_upper(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = 8'h30 + {4'd0, nib};
    end else begin
      ch = 8'h37 + {4'd0, nib};
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

@@ sv/urlre_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface urlre_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink (input valid, input in_byte, input end_of_string, output ready);
endinterface

`default_nettype wire

@@ sv/urlre_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface urlre_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_out;

  modport source (output valid, output out_byte, output last_out, input ready);
  modport sink (input valid, input out_byte, input last_out, output ready);
endinterface

`default_nettype wire

@@ sv/url_escape_reencoder.sv @@
`timescale 1ns / 1ps
`default_nettype none

// URL percent-encoding normalizer. Characters of a URL come in one per request
// on raw (end_of_string marks the final one) and the re-encoded URL goes out
// one character per request on norm, with last_out on its final character.
// A '%' with two hex digits is decoded unless the decoded byte is reserved or
// unsafe, a stray '%' and any unsafe, non-reserved byte become '%' plus two
// upper-case hex digits, everything else passes. Each character is decided
// once its two successors are in, so output trails input by two characters;
// at end of string the held characters are flushed. The front takes one
// character per cycle while the queue has space; the back emits one
// character per cycle while norm is ready, so an escaped character yields
// three output characters, a passed one one, and a decoded triplet one
// output character for three inputs. The worst case is a run of escaped
// characters, where the output limits the input. A decision is pushed into
// the queue and then loaded from its head into the output register.

module url_escape_reencoder #(
  parameter int QUEUE_DEPTH = 2   // decision queue entries, 2 to 16
) (
  input  logic        clk,
  input  logic        rst,
  urlre_in_if.sink    raw,
  urlre_out_if.source norm
);
  import urlre_pkg::*;

  // decision queue between the window logic and the byte emitter
  logic q_push;
  logic q_space;
  logic q_pop;
  logic q_head_valid;
  act_t q_act;
  act_t q_head;

  // front: three-character window, one decision per cycle while the queue has space
  urlre_front u_front (
    .clk     (clk),
    .rst     (rst),
    .raw     (raw),
    .q_space (q_space),
    .q_push  (q_push),
    .q_act   (q_act)
  );

  urlre_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_act   (q_act),
    .space      (q_space),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_act   (q_head)
  );

  // back: expands each decision into one or three output characters,
  // held in an output register so the queue keeps filling during stalls
  urlre_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head_act   (q_head),
    .pop        (q_pop),
    .norm       (norm)
  );

endmodule

`default_nettype wire

@@ sv/urlre_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module urlre_front (
  input  logic          clk,
  input  logic          rst,
  urlre_in_if.sink      raw,
  input  logic          q_space,
  output logic          q_push,
  output urlre_pkg::act_t q_act
);
  import urlre_pkg::*;

  logic [7:0] win [3];
  logic [7:0] win_next [3];
  logic [1:0] cnt;
  logic [1:0] cnt_next;
  logic       drain;
  logic       drain_next;

  logic       want;
  logic       fire;
  logic       accept;
  logic       three_ok;
  logic [7:0] dec_val;
  logic [1:0] consume;
  logic [1:0] base;
  act_t       act;

  always_comb begin
    want     = (cnt == 2'd3) || (drain && cnt != 2'd0);
    fire     = want && q_space;
    three_ok = (cnt == 2'd3) && is_hex(win[1]) && is_hex(win[2]);
    dec_val  = {hex_val(win[1]), hex_val(win[2])};

    act.data = win[0];
    act.esc  = 1'b0;
    consume  = 2'd1;
    if (win[0] == PCT_CHAR) begin
      if (three_ok && char_class(dec_val) == CLS_NONE) begin
        act.data = dec_val;
        consume  = 2'd3;
      end else if (!three_ok) begin
        act.esc = 1'b1;
      end
    end else begin
      act.esc = (char_class(win[0]) == CLS_UNSAFE);
    end
    act.last = drain && (cnt == consume);

    base      = fire ? (cnt - consume) : cnt;
    raw.ready = !drain && (cnt != 2'd3 || fire);
    accept    = raw.valid && raw.ready;

    win_next = win;
    if (fire && consume == 2'd1) begin
      win_next[0] = win[1];
      win_next[1] = win[2];
    end
    if (accept) begin
      win_next[base] = raw.in_byte;
    end
    cnt_next = base + {1'b0, accept};

    drain_next = drain;
    if (accept && raw.end_of_string) begin
      drain_next = 1'b1;
    end else if (fire && act.last) begin
      drain_next = 1'b0;
    end
  end

  assign q_push = fire;
  assign q_act  = act;

  always_ff @(posedge clk) begin
    win <= win_next;
    if (rst) begin
      cnt   <= 2'd0;
      drain <= 1'b0;
    end else begin
      cnt   <= cnt_next;
      drain <= drain_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/urlre_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module urlre_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  urlre_pkg::act_t push_act,
  output logic            space,
  input  logic            pop,
  output logic            head_valid,
  output urlre_pkg::act_t head_act
);
  import urlre_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

  act_t          mem [DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [CW-1:0] fill;

  assign space      = (fill != CW'(DEPTH));
  assign head_valid = (fill != '0);
  assign head_act   = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_act;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wp <= (wp == LAST_SLOT) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == LAST_SLOT) ? '0 : rp + 1'b1;
      end
      fill <= fill + CW'(push) - CW'(pop);
    end
  end

endmodule

`default_nettype wire

@@ sv/urlre_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module urlre_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  urlre_pkg::act_t head_act,
  output logic            pop,
  urlre_out_if.source     norm
);
  import urlre_pkg::*;

  logic [1:0] phase;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_last;

  logic       load;
  logic       final_piece;
  logic [7:0] piece;

  always_comb begin
    load        = !out_valid || norm.ready;
    final_piece = !head_act.esc || phase == 2'd2;
    unique case (phase)
      2'd1:    piece = hex_upper(head_act.data[7:4]);
      2'd2:    piece = hex_upper(head_act.data[3:0]);
      default: piece = head_act.esc ? PCT_CHAR : head_act.data;
    endcase
    pop = load && head_valid && final_piece;
  end

  assign norm.valid    = out_valid;
  assign norm.out_byte = out_byte;
  assign norm.last_out = out_last;

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      out_byte <= piece;
      out_last <= head_act.last && final_piece;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= 2'd0;
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= head_valid;
      if (head_valid) begin
        phase <= final_piece ? 2'd0 : phase + 2'd1;
      end
    end
  end

endmodule

`default_nettype wire
